@@ design/islip_pkg.sv @@
// ----------------------------------------------------------------------------
// islip_pkg
// Shared widths, limits and state encoding for the iSLIP crossbar scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package islip_pkg;

   // Field widths fixed by the external interface
   localparam int MATRIX_W   = 64;
   localparam int CSR_W      = 4;
   localparam int ROUNDS_W   = 4;

   // Largest round count a result can report
   localparam int MAX_ROUNDS = 8;

   // Round reset value for the iteration limit register
   localparam logic [CSR_W-1:0] MAX_ITER_RESET = 4'd4;

   // Sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

`default_nettype wire

@@ design/islip_rr_arb.sv @@
// ----------------------------------------------------------------------------
// islip_rr_arb
// One round-robin lane: picks the first set request at or after the pointer,
// wrapping at PORTS, and reports the winner plus the pointer value after it.
// ----------------------------------------------------------------------------
`default_nettype none

module islip_rr_arb #(
   parameter int PORTS = 8
) (
   input  wire logic                      enable,
   input  wire logic [PORTS-1:0]          req,
   input  wire logic [$clog2(PORTS)-1:0]  ptr,
   output logic                           found,
   output logic [PORTS-1:0]               grant_oh,
   output logic [$clog2(PORTS)-1:0]       next_ptr
);

   localparam int PTR_W = $clog2(PORTS);

   logic [PTR_W-1:0] win;

   // Circular scan from the pointer
   always_comb begin
      logic [PTR_W:0] pos;
      found = 1'b0;
      win   = '0;
      pos   = '0;
      for (int s = 0; s < PORTS; s++) begin
         pos = {1'b0, ptr} + (PTR_W+1)'(s);
         if (pos >= (PTR_W+1)'(PORTS)) begin
            pos = pos - (PTR_W+1)'(PORTS);
         end
         if (!found && enable && req[pos[PTR_W-1:0]]) begin
            found = 1'b1;
            win   = pos[PTR_W-1:0];
         end
      end
   end

   // One-hot winner
   always_comb begin
      for (int k = 0; k < PORTS; k++) begin
         grant_oh[k] = found && (win == PTR_W'(k));
      end
   end

   // Pointer to the port after the winner
   assign next_ptr = (win == PTR_W'(PORTS - 1)) ? '0 : win + PTR_W'(1);

endmodule

`default_nettype wire

@@ design/islip_crossbar_scheduler.sv @@
// ----------------------------------------------------------------------------
// islip_crossbar_scheduler
// iSLIP request-grant-accept scheduler for a PORTS x PORTS VOQ crossbar.
// One grant lane per output and one accept lane per input run side by side;
// the merge logic folds the accepts into the match matrix and pointers.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-------------------------------
//   req      | in        | req_valid/req_stall | req_requests
//   rsp      | out       | rsp_valid/rsp_stall | rsp_matches_res, rsp_rounds_run
//   csr      | in        | csr_write_enable    | csr_write_data
//
// An item is loaded while the sequencer is idle; then the arbiter lanes complete
// a single grant-accept round each clock until a round makes no accept or the
// round limit is reached. A round limit of zero skips the rounds altogether.
// A new item is taken only while the sequencer is idle; a finished result
// sits in the output register, so one further item may run beneath it.
// When the output register is still stalled at the end of a run, the result
// waits in the working registers until it drains.
// Reset (synchronous, active high) clears all pointers, the limit register
// to 4 and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module islip_crossbar_scheduler #(
   parameter int PORTS = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [islip_pkg::MATRIX_W-1:0]    req_requests,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [islip_pkg::MATRIX_W-1:0]         rsp_matches_res,
   output logic [islip_pkg::ROUNDS_W-1:0]         rsp_rounds_run,
   // configuration
   input  wire logic                              csr_write_enable,
   input  wire logic [islip_pkg::CSR_W-1:0]       csr_write_data
);

   localparam int PTR_W = $clog2(PORTS);
   localparam int MW    = islip_pkg::MATRIX_W;
   localparam int RW    = islip_pkg::ROUNDS_W;
   localparam logic [islip_pkg::CSR_W-1:0] PORT_LIMIT = islip_pkg::CSR_W'(PORTS);

   // Control state
   islip_pkg::state_type         state_ff, state_in;
   logic [islip_pkg::CSR_W-1:0]  max_iter_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [PTR_W-1:0]             acc_ptr_ff [PORTS];
   logic [PTR_W-1:0]             acc_ptr_in [PORTS];
   logic [PTR_W-1:0]             gnt_ptr_ff [PORTS];
   logic [PTR_W-1:0]             gnt_ptr_in [PORTS];

   // Working registers
   logic [MW-1:0]                reqs_ff, reqs_in;
   logic [MW-1:0]                match_ff, match_in;
   logic [RW-1:0]                rounds_ff, rounds_in;
   logic [PORTS-1:0]             in_busy_ff, in_busy_in;
   logic [PORTS-1:0]             out_busy_ff, out_busy_in;
   logic [MW-1:0]                rsp_matches_ff, rsp_matches_in;
   logic [RW-1:0]                rsp_rounds_ff, rsp_rounds_in;

   // Lane signals
   logic [PORTS-1:0]             gnt_req   [PORTS];   // per output, over inputs
   logic [PORTS-1:0]             gnt_oh    [PORTS];
   logic [PTR_W-1:0]             gnt_next  [PORTS];
   logic [PORTS-1:0]             gnt_found;
   logic [PORTS-1:0]             acc_req   [PORTS];   // per input, over outputs
   logic [PORTS-1:0]             acc_oh    [PORTS];
   logic [PTR_W-1:0]             acc_next  [PORTS];
   logic [PORTS-1:0]             acc_found;
   logic [PORTS-1:0]             out_hit;
   logic [MW-1:0]                round_match;
   logic                         round_hit;
   logic                         running;
   logic                         out_free;
   logic [islip_pkg::CSR_W-1:0]  limit;

   assign running  = (state_ff == islip_pkg::ST_RUN);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign limit    = (max_iter_ff > PORT_LIMIT) ? PORT_LIMIT : max_iter_ff;

   // Request vectors seen by each lane
   always_comb begin
      for (int j = 0; j < PORTS; j++) begin
         for (int i = 0; i < PORTS; i++) begin
            gnt_req[j][i] = reqs_ff[i*PORTS + j] && !in_busy_ff[i];
            acc_req[i][j] = gnt_oh[j][i] && !out_busy_ff[j];
         end
      end
   end

   // Grant lanes, one per output; accept lanes, one per input
   for (genvar g = 0; g < PORTS; g++) begin : g_lane
      islip_rr_arb #(.PORTS(PORTS)) u_grant (
         .enable   (running && !out_busy_ff[g]),
         .req      (gnt_req[g]),
         .ptr      (gnt_ptr_ff[g]),
         .found    (gnt_found[g]),
         .grant_oh (gnt_oh[g]),
         .next_ptr (gnt_next[g])
      );

      islip_rr_arb #(.PORTS(PORTS)) u_accept (
         .enable   (running && !in_busy_ff[g] && gnt_found[g] | (|acc_req[g])
                    && running && !in_busy_ff[g]),
         .req      (acc_req[g]),
         .ptr      (acc_ptr_ff[g]),
         .found    (acc_found[g]),
         .grant_oh (acc_oh[g]),
         .next_ptr (acc_next[g])
      );
   end

   // Merge: match bits, outputs taken this round, pointer moves
   always_comb begin
      round_match = '0;
      out_hit     = '0;
      for (int i = 0; i < PORTS; i++) begin
         acc_ptr_in[i] = acc_ptr_ff[i];
         gnt_ptr_in[i] = gnt_ptr_ff[i];
      end
      for (int i = 0; i < PORTS; i++) begin
         for (int j = 0; j < PORTS; j++) begin
            round_match[i*PORTS + j] = acc_oh[i][j];
            out_hit[j] = out_hit[j] | acc_oh[i][j];
         end
         if (acc_found[i]) begin
            acc_ptr_in[i] = acc_next[i];
         end
      end
      for (int j = 0; j < PORTS; j++) begin
         if (out_hit[j]) begin
            gnt_ptr_in[j] = gnt_next[j];
         end
      end
   end

   assign round_hit = |acc_found;

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      reqs_in        = reqs_ff;
      match_in       = match_ff;
      rounds_in      = rounds_ff;
      in_busy_in     = in_busy_ff;
      out_busy_in    = out_busy_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_matches_in = rsp_matches_ff;
      rsp_rounds_in  = rsp_rounds_ff;

      unique case (state_ff)
         islip_pkg::ST_IDLE: begin
            if (req_valid) begin
               reqs_in     = req_requests;
               match_in    = '0;
               rounds_in   = '0;
               in_busy_in  = '0;
               out_busy_in = '0;
               state_in    = (limit == '0) ? islip_pkg::ST_DONE : islip_pkg::ST_RUN;
            end
         end
         islip_pkg::ST_RUN: begin
            match_in    = match_ff | round_match;
            rounds_in   = rounds_ff + RW'(1);
            in_busy_in  = in_busy_ff | acc_found;
            out_busy_in = out_busy_ff | out_hit;
            if (!round_hit || (rounds_in == RW'(limit))) begin
               if (out_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_matches_in = match_in;
                  rsp_rounds_in  = rounds_in;
                  state_in       = islip_pkg::ST_IDLE;
               end else begin
                  state_in       = islip_pkg::ST_DONE;
               end
            end
         end
         islip_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_matches_in = match_ff;
               rsp_rounds_in  = rounds_ff;
               state_in       = islip_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = islip_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= islip_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         max_iter_ff  <= islip_pkg::MAX_ITER_RESET;
         for (int k = 0; k < PORTS; k++) begin
            acc_ptr_ff[k] <= '0;
            gnt_ptr_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            max_iter_ff <= csr_write_data;
         end
         for (int k = 0; k < PORTS; k++) begin
            acc_ptr_ff[k] <= acc_ptr_in[k];
            gnt_ptr_ff[k] <= gnt_ptr_in[k];
         end
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      reqs_ff        <= reqs_in;
      match_ff       <= match_in;
      rounds_ff      <= rounds_in;
      in_busy_ff     <= in_busy_in;
      out_busy_ff    <= out_busy_in;
      rsp_matches_ff <= rsp_matches_in;
      rsp_rounds_ff  <= rsp_rounds_in;
   end

   assign req_stall       = (state_ff != islip_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_matches_res = rsp_matches_ff;
   assign rsp_rounds_run  = rsp_rounds_ff;

endmodule

`default_nettype wire

@@ design/islip_checker.sv @@
// ----------------------------------------------------------------------------
// islip_checker
// Port-level checks on the scheduler's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module islip_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic [islip_pkg::MATRIX_W-1:0] rsp_matches_res,
   input  wire logic [islip_pkg::ROUNDS_W-1:0] rsp_rounds_run
);

   // No result shows right after reset
   a_reset_clears: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_matches_res)
                                 && $stable(rsp_rounds_run))
      else $error("stalled result changed");

   // No rounds run means nothing matched
   a_zero_rounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_rounds_run == '0) |-> (rsp_matches_res == '0))
      else $error("matches without any round");

   // Every round but the last added at least one match
   a_progress: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_rounds_run != '0)
      |-> ($countones(rsp_matches_res) + 1 >= int'(rsp_rounds_run)))
      else $error("round count exceeds accepted matches");

   // Round count bounded
   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_rounds_run) <= islip_pkg::MAX_ROUNDS))
      else $error("round count out of range");

endmodule

bind islip_crossbar_scheduler islip_checker u_islip_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_matches_res (rsp_matches_res),
   .rsp_rounds_run  (rsp_rounds_run)
);

`default_nettype wire
